// ----- sv/swgc_pkg.sv -----
// swgc_pkg: shared types and constants for the seed word group codec.
// Used by every module of the block; no dependencies.
`default_nettype none
package swgc_pkg;
	localparam int IDX_W = 12;
	localparam int VAL_W = 32;
	localparam int FIFO_DEPTH = 2;
	localparam logic [IDX_W-1:0] RESET_WORD_COUNT = 12'd1626;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	typedef struct packed {
		logic             operation;
		logic [VAL_W-1:0] group_value;
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] second_index;
		logic [IDX_W-1:0] third_index;
	} swgc_in_t;

	typedef struct packed {
		logic [VAL_W-1:0] decoded_value;
		logic [IDX_W-1:0] word_a;
		logic [IDX_W-1:0] word_b;
		logic [IDX_W-1:0] word_c;
	} swgc_out_t;

	// classified item handed from front to back
	typedef struct packed {
		logic             operation;
		logic [IDX_W-1:0] radix;
		logic [VAL_W-1:0] div_a;   // encode: group value; decode: n - i1 + i2
		logic [VAL_W-1:0] div_b;   // decode: n - i2 + i3
		logic [IDX_W-1:0] first_index;
	} swgc_job_t;
endpackage
`default_nettype wire

// ----- sv/swgc_front.sv -----
// swgc_front: accepts commands, resolves the radix and forms the dividends.
// Depends on swgc_pkg.
`default_nettype none
module swgc_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   accept,
	input  swgc_pkg::swgc_in_t    cmd,
	input  wire [swgc_pkg::IDX_W-1:0] word_count,
	output logic                  job_valid,
	output swgc_pkg::swgc_job_t   job
);
	import swgc_pkg::*;

	logic [IDX_W-1:0] n;
	logic [VAL_W-1:0] n_x, i1_x, i2_x, i3_x;
	logic             valid_s1;
	swgc_job_t        job_s1;

	always_comb begin
		n = (word_count == '0) ? IDX_W'(1) : word_count;
		n_x  = {{(VAL_W-IDX_W){1'b0}}, n};
		i1_x = {{(VAL_W-IDX_W){1'b0}}, cmd.first_index};
		i2_x = {{(VAL_W-IDX_W){1'b0}}, cmd.second_index};
		i3_x = {{(VAL_W-IDX_W){1'b0}}, cmd.third_index};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1.operation   <= cmd.operation;
			job_s1.radix       <= n;
			job_s1.div_a       <= (cmd.operation == OP_DECODE) ? (n_x - i1_x + i2_x)
			                                                   : cmd.group_value;
			job_s1.div_b       <= n_x - i2_x + i3_x;
			job_s1.first_index <= cmd.first_index;
		end
	end

	assign job_valid = valid_s1;
	assign job       = job_s1;
endmodule
`default_nettype wire

// ----- sv/swgc_fifo.sv -----
// swgc_fifo: short job queue between front and back.
// Depends on swgc_pkg.
`default_nettype none
module swgc_fifo #(
	parameter int DEPTH = swgc_pkg::FIFO_DEPTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  swgc_pkg::swgc_job_t push_data,
	input  wire                 pop,
	output logic                empty,
	output logic                full,
	output swgc_pkg::swgc_job_t pop_data
);
	import swgc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	swgc_job_t        mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign empty    = (cnt_q == '0);
	assign full     = (cnt_q == CW'(DEPTH));
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

// ----- sv/swgc_div.sv -----
// swgc_div: pipelined restoring divider, one quotient bit per stage.
// Carries an opaque sideband word alongside; depends on swgc_pkg.
`default_nettype none
module swgc_div #(
	parameter int W   = swgc_pkg::VAL_W,
	parameter int DW  = swgc_pkg::IDX_W,
	parameter int SBW = 1
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	input  wire  [W-1:0]   dividend,
	input  wire  [DW-1:0]  divisor,
	input  wire  [SBW-1:0] sb_in,
	output logic           out_valid,
	output logic [W-1:0]   quotient,
	output logic [DW-1:0]  remainder,
	output logic [SBW-1:0] sb_out
);
	import swgc_pkg::*;

	// index 0 is the input side, index k the register after stage k
	logic           vld_q [0:W];
	logic [W-1:0]   acc_q [0:W];
	logic [DW-1:0]  rem_q [0:W];
	logic [DW-1:0]  dvs_q [0:W];
	logic [SBW-1:0] sb_q  [0:W];

	assign vld_q[0] = in_valid;
	assign acc_q[0] = dividend;
	assign rem_q[0] = '0;
	assign dvs_q[0] = divisor;
	assign sb_q[0]  = sb_in;

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;
		logic [DW-1:0] rem_nx;

		always_comb begin
			trial  = {rem_q[k], acc_q[k][W-1]};
			diff   = trial - {1'b0, dvs_q[k]};
			ge     = (trial >= {1'b0, dvs_q[k]});
			rem_nx = ge ? diff[DW-1:0] : trial[DW-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else begin
				vld_q[k+1] <= vld_q[k];
			end
		end

		always_ff @(posedge clk) begin
			acc_q[k+1] <= {acc_q[k][W-2:0], ge};
			rem_q[k+1] <= rem_nx;
			dvs_q[k+1] <= dvs_q[k];
			sb_q[k+1]  <= sb_q[k];
		end
	end

	assign out_valid = vld_q[W];
	assign quotient  = acc_q[W];
	assign remainder = rem_q[W];
	assign sb_out    = sb_q[W];
endmodule
`default_nettype wire

// ----- sv/swgc_back.sv -----
// swgc_back: three chained dividers, then multiply and sum for decode.
// Depends on swgc_pkg and swgc_div.
`default_nettype none
module swgc_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 job_valid,
	input  swgc_pkg::swgc_job_t job,
	output logic                done,
	output swgc_pkg::swgc_out_t result
);
	import swgc_pkg::*;

	localparam int SBA = 1 + IDX_W + VAL_W + IDX_W;
	localparam int SBB = 1 + IDX_W + IDX_W + IDX_W;
	localparam int SBC = 1 + IDX_W + IDX_W + IDX_W + IDX_W;

	// unit A: encode x / n ; decode d1
	logic             va;
	logic [VAL_W-1:0] qa;
	logic [IDX_W-1:0] ra, ra_n;
	logic [SBA-1:0]   sba;
	logic             op_a;
	logic [IDX_W-1:0] i1_a;
	logic [VAL_W-1:0] divb_a;

	swgc_div #(.W(VAL_W), .DW(IDX_W), .SBW(SBA)) u_div_a (
		.clk, .arst_n,
		.in_valid (job_valid),
		.dividend (job.div_a),
		.divisor  (job.radix),
		.sb_in    ({job.operation, job.first_index, job.div_b, job.radix}),
		.out_valid(va),
		.quotient (qa),
		.remainder(ra),
		.sb_out   (sba)
	);
	assign {op_a, i1_a, divb_a, ra_n} = sba;

	// unit B: encode (x/n) / n ; decode d2
	logic             vb;
	logic [VAL_W-1:0] qb;
	logic [IDX_W-1:0] rb, rb_n, i1_b, ra_b;
	logic [SBB-1:0]   sbb;
	logic             op_b;

	swgc_div #(.W(VAL_W), .DW(IDX_W), .SBW(SBB)) u_div_b (
		.clk, .arst_n,
		.in_valid (va),
		.dividend ((op_a == OP_DECODE) ? divb_a : qa),
		.divisor  (ra_n),
		.sb_in    ({op_a, i1_a, ra, ra_n}),
		.out_valid(vb),
		.quotient (qb),
		.remainder(rb),
		.sb_out   (sbb)
	);
	assign {op_b, i1_b, ra_b, rb_n} = sbb;

	// word_b = (x/n mod n + word_a) mod n, both below n
	logic [IDX_W:0]   bsum, bsub;
	logic [IDX_W-1:0] wb;
	logic [VAL_W-1:0] divc;
	always_comb begin
		bsum = {1'b0, rb} + {1'b0, ra_b};
		bsub = bsum - {1'b0, rb_n};
		wb   = (bsum >= {1'b0, rb_n}) ? bsub[IDX_W-1:0] : bsum[IDX_W-1:0];
		divc = (op_b == OP_DECODE) ? '0 : qb + {{(VAL_W-IDX_W){1'b0}}, wb};
	end

	// unit C: word_c
	logic             vc;
	logic [VAL_W-1:0] qc;
	logic [IDX_W-1:0] rc, n_c, i1_c, x_c, y_c;
	logic [SBC-1:0]   sbc;
	logic             op_c;

	swgc_div #(.W(VAL_W), .DW(IDX_W), .SBW(SBC)) u_div_c (
		.clk, .arst_n,
		.in_valid (vb),
		.dividend (divc),
		.divisor  (rb_n),
		.sb_in    ({op_b, i1_b, ra_b, ((op_b == OP_DECODE) ? rb : wb), rb_n}),
		.out_valid(vc),
		.quotient (qc),
		.remainder(rc),
		.sb_out   (sbc)
	);
	assign {op_c, i1_c, x_c, y_c, n_c} = sbc;

	// x_c: word_a or d1 ; y_c: word_b or d2
	logic                   v_s1, v_s2, v_s3;
	logic                   op_s1, op_s2;
	logic [IDX_W-1:0]       a_s1, b_s1, c_s1, n_s1, i1_s1, a_s2, b_s2, c_s2;
	logic [2*IDX_W-1:0]     p1_s1, p2_s1;
	logic [3*IDX_W-1:0]     p3;
	logic [VAL_W-1:0]       sum_s2, p3_s2;
	swgc_out_t              res_s3;

	assign p3 = (3*IDX_W)'(p2_s1) * (3*IDX_W)'(n_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= vc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= op_c;
		a_s1   <= x_c;
		b_s1   <= y_c;
		c_s1   <= rc;
		n_s1   <= n_c;
		i1_s1  <= i1_c;
		p1_s1  <= (2*IDX_W)'(n_c) * (2*IDX_W)'(x_c);
		p2_s1  <= (2*IDX_W)'(n_c) * (2*IDX_W)'(y_c);

		op_s2  <= op_s1;
		a_s2   <= a_s1;
		b_s2   <= b_s1;
		c_s2   <= c_s1;
		sum_s2 <= {{(VAL_W-IDX_W){1'b0}}, i1_s1} + {{(VAL_W-2*IDX_W){1'b0}}, p1_s1};
		p3_s2  <= p3[VAL_W-1:0];

		if (op_s2 == OP_DECODE) begin
			res_s3.decoded_value <= sum_s2 + p3_s2;
			res_s3.word_a        <= '0;
			res_s3.word_b        <= '0;
			res_s3.word_c        <= '0;
		end else begin
			res_s3.decoded_value <= '0;
			res_s3.word_a        <= a_s2;
			res_s3.word_b        <= b_s2;
			res_s3.word_c        <= c_s2;
		end
	end

	assign done   = v_s3;
	assign result = res_s3;
endmodule
`default_nettype wire

// ----- sv/seed_word_group_codec.sv -----
// seed_word_group_codec: top level; config register, front, queue, back.
// Depends on swgc_pkg, swgc_front, swgc_fifo, swgc_back.
//
//   channel   handshake               beat
//   -------   ---------------------   -----------------------------
//   command   start / busy            cmd    (swgc_in_t)
//   result    done (strobe)           result (swgc_out_t)
//   config    cfg_valid / cfg_ready   cfg_data (word_count, 12 bit)
//
// A command beat is taken every cycle that start is high and busy is low.
// From command to result a job passes one front register, one queue slot,
// 3 x 32 divider stages (one quotient bit each) and three
// multiply/sum/output stages. The divider chain makes up most of that path.
// The back end never stalls, so the queue never fills and busy stays low in
// normal use. arst_n clears all valid bits and resets word_count to 1626.
// Results are shown for one cycle under done; the receiver cannot hold them.
`default_nettype none
module seed_word_group_codec #(
	parameter int FIFO_DEPTH = swgc_pkg::FIFO_DEPTH
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	output logic                      busy,
	input  swgc_pkg::swgc_in_t        cmd,
	output logic                      done,
	output swgc_pkg::swgc_out_t       result,
	input  wire                       cfg_valid,
	output logic                      cfg_ready,
	input  wire [swgc_pkg::IDX_W-1:0] cfg_data
);
	import swgc_pkg::*;

	logic [IDX_W-1:0] word_count_q;
	logic             accept;
	logic             job_valid, fifo_empty, fifo_full, pop;
	swgc_job_t        job_front, job_back;

	assign cfg_ready = 1'b1;
	assign busy      = fifo_full;
	assign accept    = start && !busy;
	// back end always advances, so any queued job leaves at once
	assign pop       = !fifo_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= RESET_WORD_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			word_count_q <= cfg_data;
		end
	end

	swgc_front u_front (
		.clk, .arst_n,
		.accept    (accept),
		.cmd       (cmd),
		.word_count(word_count_q),
		.job_valid (job_valid),
		.job       (job_front)
	);

	swgc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk, .arst_n,
		.push     (job_valid),
		.push_data(job_front),
		.pop      (pop),
		.empty    (fifo_empty),
		.full     (fifo_full),
		.pop_data (job_back)
	);

	swgc_back u_back (
		.clk, .arst_n,
		.job_valid(pop),
		.job      (job_back),
		.done     (done),
		.result   (result)
	);

	// outstanding items, for checking only
	logic [7:0] outst_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else if (accept && !done) begin
			outst_q <= outst_q + 1'b1;
		end else if (done && !accept) begin
			outst_q <= outst_q - 1'b1;
		end
	end

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (outst_q != '0))
		else $error("result without a pending command");

	a_queue_never_full: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> !fifo_full)
		else $error("job pushed into full queue");

	a_one_mode: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.decoded_value == '0 ||
		          (result.word_a == '0 && result.word_b == '0 && result.word_c == '0)))
		else $error("result carries both encode and decode fields");
endmodule
`default_nettype wire

// ----- dv/seed_word_group_codec_tb.sv -----
// seed_word_group_codec_tb: self-checking testbench for the seed word group codec.
// Depends on swgc_pkg and seed_word_group_codec; drives command and config beats,
// predicts each result and compares it against the done strobe output.
`default_nettype none
module seed_word_group_codec_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import swgc_pkg::*;

	// drain margin beyond the block's pipeline depth
	localparam int DRAIN_CYCLES = 140;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	swgc_in_t             cmd;
	logic                 done;
	swgc_out_t            result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [IDX_W-1:0]     cfg_data;

	// predictor copy of the radix register
	logic [IDX_W-1:0]     radix_reg;
	swgc_out_t            pending_words[$];
	int                   fail_count;

	// directed rows; has_exp marks rows whose result is typed in
	typedef struct {
		swgc_in_t  beat;
		logic      has_exp;
		swgc_out_t exp;
	} row_t;
	row_t dir_rows[$];

	seed_word_group_codec u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// hard stop well above the slowest legal run
	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

	// encode / decode predictor at the block's 32-bit widths
	function automatic swgc_out_t codec_words(swgc_in_t c, logic [IDX_W-1:0] nreg);
		logic [31:0] n;
		logic [31:0] v;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] cw;
		logic [31:0] d1;
		logic [31:0] d2;
		logic [31:0] i1;
		logic [31:0] i2;
		logic [31:0] i3;
		swgc_out_t   r;
		n = (nreg == '0) ? 32'd1 : {20'd0, nreg};
		r = '0;
		if (c.operation == OP_ENCODE) begin
			v  = c.group_value;
			a  = v % n;
			b  = (v / n + a) % n;
			cw = (v / n / n + b) % n;
			r.word_a = a[IDX_W-1:0];
			r.word_b = b[IDX_W-1:0];
			r.word_c = cw[IDX_W-1:0];
		end else begin
			i1 = {20'd0, c.first_index};
			i2 = {20'd0, c.second_index};
			i3 = {20'd0, c.third_index};
			d1 = ((n - i1) + i2) % n;
			d2 = ((n - i2) + i3) % n;
			r.decoded_value = i1 + n * d1 + n * n * d2;
		end
		return r;
	endfunction

	// result monitor: sample on rising edge
	always @(posedge clk) begin
		swgc_out_t e;
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				$error("result beat with nothing expected");
				fail_count++;
			end else begin
				e = pending_words.pop_front();
				if (result.decoded_value !== e.decoded_value) begin
					$error("decoded_value exp %h act %h", e.decoded_value, result.decoded_value);
					fail_count++;
				end
				if (result.word_a !== e.word_a) begin
					$error("word_a exp %0d act %0d", e.word_a, result.word_a);
					fail_count++;
				end
				if (result.word_b !== e.word_b) begin
					$error("word_b exp %0d act %0d", e.word_b, result.word_b);
					fail_count++;
				end
				if (result.word_c !== e.word_c) begin
					$error("word_c exp %0d act %0d", e.word_c, result.word_c);
					fail_count++;
				end
			end
		end
	end

	// one command beat, then start is dropped before return; exp_in used when the result is typed in
	task automatic send_beat(swgc_in_t c, logic use_exp, swgc_out_t exp_in);
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		pending_words = {pending_words, (use_exp ? exp_in : codec_words(c, radix_reg))};
		@(negedge clk);
		start <= 1'b0;
		@(negedge clk);
	endtask

	// wait out every pending result plus the pipe depth, then write word_count
	task automatic write_radix(logic [IDX_W-1:0] n);
		while (pending_words.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= n;
		do @(posedge clk); while (!cfg_ready);
		radix_reg = n;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic swgc_in_t rand_beat(logic [IDX_W-1:0] n);
		swgc_in_t c;
		int       nn;
		nn = (n == '0) ? 1 : int'(n);
		c.operation   = 1'($urandom_range(0, 1));
		c.group_value = $urandom();
		case ($urandom_range(0, 7))
			0: c.group_value = 32'hFFFF_FFFF - $urandom_range(0, 3);
			1: c.group_value = $urandom_range(0, 3);
			default: ;
		endcase
		// mostly in range, sometimes any 12-bit value
		if ($urandom_range(0, 4) == 0) begin
			c.first_index  = IDX_W'($urandom());
			c.second_index = IDX_W'($urandom());
			c.third_index  = IDX_W'($urandom());
		end else begin
			c.first_index  = IDX_W'($urandom_range(0, nn - 1));
			c.second_index = IDX_W'($urandom_range(0, nn - 1));
			c.third_index  = IDX_W'($urandom_range(0, nn - 1));
		end
		return c;
	endfunction

	function automatic row_t mk_row(logic op, logic [31:0] v, logic [IDX_W-1:0] i1,
			logic [IDX_W-1:0] i2, logic [IDX_W-1:0] i3, logic he, swgc_out_t ex);
		row_t r;
		r.beat.operation    = op;
		r.beat.group_value  = v;
		r.beat.first_index  = i1;
		r.beat.second_index = i2;
		r.beat.third_index  = i3;
		r.has_exp = he;
		r.exp     = ex;
		return r;
	endfunction

	initial begin
		logic [IDX_W-1:0] radix_set[$];
		swgc_out_t        z;
		row_t             rw;
		int               burst;
		int               sent;
		int               per_phase;
		fail_count = 0;
		radix_reg  = RESET_WORD_COUNT;
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows at the reset radix 1626
		z = '0;
		dir_rows = {dir_rows, mk_row(OP_ENCODE, 32'd0, 12'd0, 12'd0, 12'd0, 1'b1, z)};
		dir_rows = {dir_rows, mk_row(OP_DECODE, 32'd0, 12'd0, 12'd0, 12'd0, 1'b1, z)};
		// unused fields carry noise; output must ignore them
		dir_rows = {dir_rows, mk_row(OP_ENCODE, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF, 12'hFFF,
			1'b0, z)};
		dir_rows = {dir_rows, mk_row(OP_DECODE, 32'hFFFF_FFFF, 12'd1625, 12'd1625, 12'd1625,
			1'b0, z)};
		// index at or above radix: wraps, no error
		dir_rows = {dir_rows, mk_row(OP_DECODE, 32'd0, 12'hFFF, 12'd0, 12'hFFF, 1'b0, z)};
		dir_rows = {dir_rows, mk_row(OP_DECODE, 32'd0, 12'd5, 12'd1, 12'd0, 1'b0, z)};
		dir_rows = {dir_rows, mk_row(OP_ENCODE, 32'h0403_0201, 12'd0, 12'd0, 12'd0, 1'b0, z)};
		dir_rows = {dir_rows, mk_row(OP_ENCODE, 32'd1625, 12'd0, 12'd0, 12'd0, 1'b0, z)};
		dir_rows = {dir_rows, mk_row(OP_ENCODE, 32'd1626, 12'd0, 12'd0, 12'd0, 1'b0, z)};
		dir_rows = {dir_rows, mk_row(OP_ENCODE, 32'h8000_0000, 12'd0, 12'd0, 12'd0, 1'b0, z)};
		foreach (dir_rows[k])
			send_beat(dir_rows[k].beat, dir_rows[k].has_exp, dir_rows[k].exp);

		// radix of one and zero radix: every encoded digit is 0, decode returns first
		write_radix(12'd1);
		rw = mk_row(OP_ENCODE, 32'hDEAD_BEEF, 12'd0, 12'd0, 12'd0, 1'b0, z);
		send_beat(rw.beat, 1'b1, z);
		z.decoded_value = 32'd7;
		rw = mk_row(OP_DECODE, 32'd0, 12'd7, 12'd9, 12'd3, 1'b0, z);
		send_beat(rw.beat, 1'b0, z);
		write_radix(12'd0);
		z = '0;
		rw = mk_row(OP_ENCODE, 32'hFFFF_FFFF, 12'd0, 12'd0, 12'd0, 1'b0, z);
		send_beat(rw.beat, 1'b1, z);
		z.decoded_value = 32'd4095;
		rw = mk_row(OP_DECODE, 32'd0, 12'hFFF, 12'hFFF, 12'd0, 1'b0, z);
		send_beat(rw.beat, 1'b1, z);

		// random phases over several radix settings, extremes included
		radix_set = '{12'd2, 12'd4095, 12'd1626, 12'd2048, 12'd3, 12'd1};
		for (int k = 0; k < 4; k++)
			radix_set = {radix_set, IDX_W'($urandom_range(2, 4095))};
		per_phase = 1850 / radix_set.size();
		foreach (radix_set[p]) begin
			write_radix(radix_set[p]);
			sent = 0;
			while (sent < per_phase) begin
				// burst back to back, then a random gap (sometimes none)
				burst = $urandom_range(1, 40);
				for (int b = 0; b < burst && sent < per_phase; b++) begin
					send_beat_keep(rand_beat(radix_reg));
					sent++;
				end
				// a phase always ends with start low
				if (sent >= per_phase || $urandom_range(0, 3) != 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 12)) @(negedge clk);
				end
			end
		end

		while (pending_words.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending_words.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// back-to-back beat: start stays high, only cmd changes at the falling edge
	task automatic send_beat_keep(swgc_in_t c);
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		pending_words = {pending_words, codec_words(c, radix_reg)};
		@(negedge clk);
	endtask
endmodule
`default_nettype wire

// ----- sim.f -----
sv/swgc_pkg.sv
sv/swgc_front.sv
sv/swgc_fifo.sv
sv/swgc_div.sv
sv/swgc_back.sv
sv/seed_word_group_codec.sv
dv/seed_word_group_codec_tb.sv
